// ----- rtl/core/nor_flash_command_sequencer_macros.svh -----
// Assertion macros shared by the NOR flash command sequencer modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define NOR_FLASH_COMMAND_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NFCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfcs same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NFCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nfcs next-cycle check failed");

`endif

// ----- rtl/core/nfcs_pkg.sv -----
// Shared types and constants of the NOR flash command sequencer.
// Depends on nothing; used by the front, queue, back and top modules.
package nfcs_pkg;

   // Fixed widths of the external fields and depth of the job queue.
   localparam int AddrW  = 24;
   localparam int WordW  = 16;
   localparam int QueueDepth = 4;

   // Request commands.
   localparam logic [3:0] CMD_PIN_SAMPLE  = 4'd0;
   localparam logic [3:0] CMD_READ_RETURN = 4'd1;
   localparam logic [3:0] CMD_READ_ID     = 4'd2;
   localparam logic [3:0] CMD_ERASE_BLOCK = 4'd3;
   localparam logic [3:0] CMD_ERASE_CHIP  = 4'd4;
   localparam logic [3:0] CMD_PROGRAM     = 4'd5;
   localparam logic [3:0] CMD_READ_WORD   = 4'd6;
   localparam logic [3:0] CMD_RESET       = 4'd7;
   localparam logic [3:0] CMD_RETURN_READ = 4'd8;

   // Result kinds.
   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_DELIVER = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   // Completion status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ERROR    = 2'd1;
   localparam logic [1:0] ST_TIMEOUT  = 2'd2;
   localparam logic [1:0] ST_REJECTED = 2'd3;

   // Job codes passed from the front to the back.
   localparam logic [3:0] JOB_REJECT      = 4'd0;
   localparam logic [3:0] JOB_DONE        = 4'd1;
   localparam logic [3:0] JOB_READ_REQ    = 4'd2;
   localparam logic [3:0] JOB_DELIVER     = 4'd3;
   localparam logic [3:0] JOB_DELIVER_REQ = 4'd4;
   localparam logic [3:0] JOB_READ_ID     = 4'd5;
   localparam logic [3:0] JOB_ERASE_BLOCK = 4'd6;
   localparam logic [3:0] JOB_ERASE_CHIP  = 4'd7;
   localparam logic [3:0] JOB_PROGRAM     = 4'd8;
   localparam logic [3:0] JOB_READ_WORD   = 4'd9;
   localparam logic [3:0] JOB_RESET       = 4'd10;
   localparam logic [3:0] JOB_RETURN_READ = 4'd11;

   // Unlock cycle addresses (byte offsets) and command words.
   localparam logic [AddrW-1:0] UNLOCK1_ADDR = 24'h000AAA;
   localparam logic [AddrW-1:0] UNLOCK2_ADDR = 24'h000554;
   localparam logic [WordW-1:0] W_UNLOCK1     = 16'h00AA;
   localparam logic [WordW-1:0] W_UNLOCK2     = 16'h0055;
   localparam logic [WordW-1:0] W_AUTOSELECT  = 16'h0090;
   localparam logic [WordW-1:0] W_ERASE_SETUP = 16'h0080;
   localparam logic [WordW-1:0] W_BLOCK_ERASE = 16'h0030;
   localparam logic [WordW-1:0] W_CHIP_ERASE  = 16'h0010;
   localparam logic [WordW-1:0] W_PROGRAM     = 16'h00A0;
   localparam logic [WordW-1:0] W_READ_RESET  = 16'h00F0;

   // One unit of work: everything except the address.
   typedef struct packed {
      logic [3:0]       code;
      logic [WordW-1:0] word;
      logic [1:0]       idx;
      logic [1:0]       status;
   } job_type;

   // Bank offset of each ID word.
   function automatic logic [AddrW-1:0] id_word_address(input logic [1:0] idx);
      logic [AddrW-1:0] a;
      unique case (idx)
         2'd0: a = 24'h000000;
         2'd1: a = 24'h000002;
         2'd2: a = 24'h00001C;
         2'd3: a = 24'h00001E;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- rtl/core/nfcs_front.sv -----
// Front end of the NOR flash command sequencer: accepts requests, runs the
// operation state and timeout counters, and issues at most one job per request.
// Depends on nfcs_pkg and the assertion macro header.
`include "nor_flash_command_sequencer_macros.svh"

module nfcs_front import nfcs_pkg::*; #(
   parameter int JobAddrW   = 24,
   parameter int COUNT_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [3:0]          cmd,
   input  logic [JobAddrW-1:0] target_address,
   input  logic [WordW-1:0]    word_in,
   input  logic                ready_pin,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic                push,
   output job_type             job,
   output logic [JobAddrW-1:0] job_addr
);

   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_WAIT_BUSY  = 3'd1;
   localparam logic [2:0] PH_WAIT_READY = 3'd2;
   localparam logic [2:0] PH_POLL       = 3'd3;
   localparam logic [2:0] PH_ID         = 3'd4;
   localparam logic [2:0] PH_WORD       = 3'd5;

   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_BLOCK   = 2'd1;
   localparam logic [1:0] OP_CHIP    = 2'd2;
   localparam logic [1:0] OP_PROGRAM = 2'd3;

   localparam logic [1:0] REG_PROGRAM = 2'd0;
   localparam logic [1:0] REG_BLOCK   = 2'd1;
   localparam logic [1:0] REG_CHIP    = 2'd2;

   logic [COUNT_BITS-1:0] prog_limit_ff, block_limit_ff, chip_limit_ff;
   logic [2:0]            phase_ff, phase_in;
   logic [1:0]            op_ff, op_in;
   logic [COUNT_BITS-1:0] wait_ff, wait_in;
   logic [COUNT_BITS-1:0] toggle_ff, toggle_in;
   logic [1:0]            first_ff, first_in;   // DQ6 and DQ5 of the first read of a pair
   logic [1:0]            pair_ff, pair_in;
   logic [1:0]            id_step_ff, id_step_in;
   logic [COUNT_BITS-1:0] op_limit;
   logic                  busy;

   // Poll limit of the running operation.
   always_comb begin
      priority if (op_ff == OP_BLOCK) op_limit = block_limit_ff;
      else if (op_ff == OP_CHIP)      op_limit = chip_limit_ff;
      else                            op_limit = prog_limit_ff;
   end

   assign busy = (phase_ff != PH_IDLE);

   // Classify the request and work out the next state.
   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      wait_in    = wait_ff;
      toggle_in  = toggle_ff;
      first_in   = first_ff;
      pair_in    = pair_ff;
      id_step_in = id_step_ff;
      push       = 1'b0;
      job        = '0;
      job_addr   = '0;
      if (fire) begin
         priority if (cmd >= CMD_READ_ID && cmd <= CMD_RETURN_READ && busy) begin
            push       = 1'b1;
            job.code   = JOB_REJECT;
            job.status = ST_REJECTED;
         end else begin
            unique case (cmd)
               CMD_PIN_SAMPLE: begin
                  if (phase_ff == PH_WAIT_BUSY) begin
                     if (ready_pin && wait_ff != '0) begin
                        wait_in = wait_ff - 1'b1;
                     end else begin
                        wait_in  = op_limit;
                        phase_in = PH_WAIT_READY;
                     end
                  end else if (phase_ff == PH_WAIT_READY) begin
                     if (!ready_pin && wait_ff != '0) begin
                        wait_in = wait_ff - 1'b1;
                     end else if (op_limit == '0) begin
                        push       = 1'b1;
                        job.code   = JOB_DONE;
                        job.status = ST_TIMEOUT;
                        phase_in   = PH_IDLE;
                     end else begin
                        push      = 1'b1;
                        job.code  = JOB_READ_REQ;
                        toggle_in = op_limit - 1'b1;
                        pair_in   = 2'd0;
                        phase_in  = PH_POLL;
                     end
                  end
               end
               CMD_READ_RETURN: begin
                  if (phase_ff == PH_POLL) begin
                     push = 1'b1;
                     if (pair_ff == 2'd0 || pair_ff == 2'd2) begin
                        job.code = JOB_READ_REQ;
                        first_in = {word_in[6], word_in[5]};
                        pair_in  = pair_ff + 2'd1;
                     end else if (first_ff[1] == word_in[6]) begin
                        job.code   = JOB_DONE;
                        job.status = ST_OK;
                        phase_in   = PH_IDLE;
                     end else if (pair_ff == 2'd1) begin
                        job.code = JOB_READ_REQ;
                        pair_in  = 2'd2;
                     end else if (first_ff[0]) begin
                        job.code   = JOB_DONE;
                        job.status = ST_ERROR;
                        phase_in   = PH_IDLE;
                     end else if (toggle_ff == '0) begin
                        job.code   = JOB_DONE;
                        job.status = ST_TIMEOUT;
                        phase_in   = PH_IDLE;
                     end else begin
                        job.code  = JOB_READ_REQ;
                        toggle_in = toggle_ff - 1'b1;
                        pair_in   = 2'd0;
                     end
                  end else if (phase_ff == PH_WORD) begin
                     push     = 1'b1;
                     job.code = JOB_DELIVER;
                     job.word = word_in;
                     phase_in = PH_IDLE;
                  end else if (phase_ff == PH_ID) begin
                     push     = 1'b1;
                     job.word = word_in;
                     job.idx  = id_step_ff;
                     if (id_step_ff == 2'd3) begin
                        job.code   = JOB_DELIVER;
                        phase_in   = PH_IDLE;
                        id_step_in = 2'd0;
                     end else begin
                        job.code   = JOB_DELIVER_REQ;
                        id_step_in = id_step_ff + 2'd1;
                     end
                  end
               end
               CMD_READ_ID: begin
                  push       = 1'b1;
                  job.code   = JOB_READ_ID;
                  id_step_in = 2'd0;
                  phase_in   = PH_ID;
               end
               CMD_ERASE_BLOCK: begin
                  push     = 1'b1;
                  job.code = JOB_ERASE_BLOCK;
                  job_addr = target_address;
                  op_in    = OP_BLOCK;
                  wait_in  = block_limit_ff;
                  phase_in = PH_WAIT_BUSY;
               end
               CMD_ERASE_CHIP: begin
                  push     = 1'b1;
                  job.code = JOB_ERASE_CHIP;
                  op_in    = OP_CHIP;
                  wait_in  = chip_limit_ff;
                  phase_in = PH_WAIT_BUSY;
               end
               CMD_PROGRAM: begin
                  push     = 1'b1;
                  job.code = JOB_PROGRAM;
                  job.word = word_in;
                  job_addr = target_address;
                  op_in    = OP_PROGRAM;
                  wait_in  = prog_limit_ff;
                  phase_in = PH_WAIT_BUSY;
               end
               CMD_READ_WORD: begin
                  push     = 1'b1;
                  job.code = JOB_READ_WORD;
                  job_addr = target_address;
                  phase_in = PH_WORD;
               end
               CMD_RESET: begin
                  push     = 1'b1;
                  job.code = JOB_RESET;
               end
               CMD_RETURN_READ: begin
                  push     = 1'b1;
                  job.code = JOB_RETURN_READ;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Operation state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         op_ff      <= OP_NONE;
         wait_ff    <= '0;
         toggle_ff  <= '0;
         first_ff   <= '0;
         pair_ff    <= '0;
         id_step_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         op_ff      <= op_in;
         wait_ff    <= wait_in;
         toggle_ff  <= toggle_in;
         first_ff   <= first_in;
         pair_ff    <= pair_in;
         id_step_ff <= id_step_in;
      end
   end

   // Timeout registers; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         prog_limit_ff  <= COUNT_BITS'(32'd17408);
         block_limit_ff <= COUNT_BITS'(32'd10485760);
         chip_limit_ff  <= COUNT_BITS'(32'd805306368);
      end else if (csr_wr_en) begin
         if (csr_index == REG_PROGRAM) prog_limit_ff  <= csr_wdata[COUNT_BITS-1:0];
         if (csr_index == REG_BLOCK)   block_limit_ff <= csr_wdata[COUNT_BITS-1:0];
         if (csr_index == REG_CHIP)    chip_limit_ff  <= csr_wdata[COUNT_BITS-1:0];
      end
   end

   // A wait or poll phase always belongs to an erase or program operation.
   `NFCS_ASSERT_IMPLY(a_front_op_known, clock, reset, (phase_ff == PH_WAIT_BUSY || phase_ff == PH_WAIT_READY || phase_ff == PH_POLL), (op_ff != OP_NONE))

endmodule

// ----- rtl/core/nfcs_queue.sv -----
// Short job queue between the front and back of the command sequencer.
// Depends on nfcs_pkg for the depth and on the assertion macro header.
`include "nor_flash_command_sequencer_macros.svh"

module nfcs_queue import nfcs_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   logic [WIDTH-1:0] slot_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff;

   assign full       = (count_ff == CntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // Storage; the front only pushes while the queue has room.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   // Neither side may overrun or underrun the queue.
   `NFCS_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, push, (!full || pop))
   `NFCS_ASSERT_IMPLY(a_queue_no_underflow, clock, reset, pop, head_valid)

endmodule

// ----- rtl/core/nfcs_back.sv -----
// Back end of the NOR flash command sequencer: expands each queued job into
// its result beats, one per unstalled cycle, into a registered output stage.
// Depends on nfcs_pkg and the assertion macro header.
`include "nor_flash_command_sequencer_macros.svh"

module nfcs_back import nfcs_pkg::*; #(
   parameter int JobAddrW = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  job_type             head_job,
   input  logic [JobAddrW-1:0] head_addr,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [AddrW-1:0]    rsp_bus_address,
   output logic [WordW-1:0]    rsp_word_out,
   output logic [1:0]          rsp_id_index,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   logic [2:0]       step_ff;
   logic             valid_ff;
   logic [1:0]       kind_ff, idx_ff, status_ff;
   logic [AddrW-1:0] addr_ff;
   logic [WordW-1:0] word_ff;
   logic             last_ff;

   logic [1:0]       b_kind, b_idx, b_status;
   logic [AddrW-1:0] b_addr, job_addr;
   logic [WordW-1:0] b_word;
   logic             b_last;
   logic             load;

   // Zero-extend the stored job address to the bus offset width.
   always_comb begin
      job_addr = '0;
      job_addr[JobAddrW-1:0] = head_addr;
   end

   // Beat selected by the job code and the step within the job.
   always_comb begin
      b_kind   = KIND_WRITE;
      b_addr   = '0;
      b_word   = '0;
      b_idx    = '0;
      b_status = ST_OK;
      b_last   = 1'b0;
      // The unlock pair opens most command runs.
      if (step_ff == 3'd0 || step_ff == 3'd3) begin
         b_addr = UNLOCK1_ADDR;
         b_word = W_UNLOCK1;
      end else begin
         b_addr = UNLOCK2_ADDR;
         b_word = W_UNLOCK2;
      end
      unique case (head_job.code)
         JOB_REJECT, JOB_DONE: begin
            b_kind   = KIND_DONE;
            b_addr   = '0;
            b_word   = '0;
            b_status = head_job.status;
            b_last   = 1'b1;
         end
         JOB_READ_REQ: begin
            b_kind = KIND_READ;
            b_addr = '0;
            b_word = '0;
            b_last = 1'b1;
         end
         JOB_DELIVER: begin
            b_kind = KIND_DELIVER;
            b_addr = '0;
            b_word = head_job.word;
            b_idx  = head_job.idx;
            b_last = 1'b1;
         end
         JOB_DELIVER_REQ: begin
            if (step_ff == 3'd0) begin
               b_kind = KIND_DELIVER;
               b_addr = '0;
               b_word = head_job.word;
               b_idx  = head_job.idx;
            end else begin
               b_kind = KIND_READ;
               b_addr = id_word_address(head_job.idx + 2'd1);
               b_word = '0;
               b_last = 1'b1;
            end
         end
         JOB_READ_ID: begin
            if (step_ff == 3'd2) begin
               b_addr = UNLOCK1_ADDR;
               b_word = W_AUTOSELECT;
            end else if (step_ff == 3'd3) begin
               b_kind = KIND_READ;
               b_addr = id_word_address(2'd0);
               b_word = '0;
               b_last = 1'b1;
            end
         end
         JOB_ERASE_BLOCK, JOB_ERASE_CHIP: begin
            if (step_ff == 3'd2) begin
               b_addr = UNLOCK1_ADDR;
               b_word = W_ERASE_SETUP;
            end else if (step_ff == 3'd5) begin
               b_last = 1'b1;
               if (head_job.code == JOB_ERASE_BLOCK) begin
                  b_addr = job_addr;
                  b_word = W_BLOCK_ERASE;
               end else begin
                  b_addr = UNLOCK1_ADDR;
                  b_word = W_CHIP_ERASE;
               end
            end
         end
         JOB_PROGRAM: begin
            if (step_ff == 3'd2) begin
               b_addr = UNLOCK1_ADDR;
               b_word = W_PROGRAM;
            end else if (step_ff == 3'd3) begin
               b_addr = job_addr;
               b_word = head_job.word;
               b_last = 1'b1;
            end
         end
         JOB_READ_WORD: begin
            if (step_ff == 3'd2) begin
               b_addr = job_addr;
               b_word = W_READ_RESET;
            end else if (step_ff == 3'd3) begin
               b_kind = KIND_READ;
               b_addr = job_addr;
               b_word = '0;
               b_last = 1'b1;
            end
         end
         JOB_RESET: begin
            if (step_ff == 3'd2) begin
               b_addr = '0;
               b_word = W_READ_RESET;
               b_last = 1'b1;
            end
         end
         JOB_RETURN_READ: begin
            b_addr = '0;
            b_word = W_READ_RESET;
            b_last = 1'b1;
         end
         default: begin
            b_last = 1'b1;
         end
      endcase
   end

   // A beat moves into the output stage whenever that stage is free or drains.
   assign load = head_valid && (!valid_ff || !rsp_stall);
   assign pop  = load && b_last;

   // Step counter and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) step_ff <= b_last ? 3'd0 : step_ff + 3'd1;
         if (load)            valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= b_kind;
         addr_ff   <= b_addr;
         word_ff   <= b_word;
         idx_ff    <= b_idx;
         status_ff <= b_status;
         last_ff   <= b_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_bus_address = addr_ff;
   assign rsp_word_out    = word_ff;
   assign rsp_id_index    = idx_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;

   // No job runs past six beats, and a completion always closes its job.
   `NFCS_ASSERT_IMPLY(a_back_step_range, clock, reset, head_valid, (step_ff <= 3'd5))
   `NFCS_ASSERT_IMPLY(a_back_done_last, clock, reset, (valid_ff && kind_ff == KIND_DONE), last_ff)

endmodule

// ----- rtl/core/nor_flash_command_sequencer.sv -----
// Top level of the NOR flash command sequencer: front, job queue and back.
// Depends on nfcs_pkg, nfcs_front, nfcs_queue and nfcs_back.
//
//   Channel   Direction  Ports                         Handshake
//   req_      in         cmd, target_address, word_in,  req_valid / req_stall
//                        ready_pin
//   rsp_      out        kind, bus_address, word_out,   rsp_valid / rsp_stall
//                        id_index, status, last
//   csr_      in         csr_wr_en, csr_index, csr_wdata  write only
//
// The front takes one request per cycle while the four-entry job queue has room.
// The back sends one result beat per cycle while rsp_ is not stalled; a job gives
// one to six beats: six for an erase, four for program, ID or word read.
// Reset is synchronous and active high; it clears all control state and loads
// the default timeouts. A stall on rsp_ holds the output stage; the queue keeps
// taking requests until it fills, and then req_stall rises.
module nor_flash_command_sequencer import nfcs_pkg::*; #(
   parameter int ADDR_BITS  = 24,
   parameter int COUNT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [3:0]       req_cmd,
   input  logic [AddrW-1:0] req_target_address,
   input  logic [WordW-1:0] req_word_in,
   input  logic             req_ready_pin,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [AddrW-1:0] rsp_bus_address,
   output logic [WordW-1:0] rsp_word_out,
   output logic [1:0]       rsp_id_index,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);

   // Address bits the sequencer actually carries.
   localparam int JobAddrW = (ADDR_BITS < AddrW) ? ADDR_BITS : AddrW;
   localparam int QW       = $bits(job_type) + JobAddrW;

   logic                fire, push, q_full, q_valid, q_pop;
   job_type             f_job, q_job;
   logic [JobAddrW-1:0] f_addr, q_addr;
   logic [QW-1:0]       q_data;

   assign req_stall = q_full;
   assign fire      = req_valid && !q_full;
   assign {q_job, q_addr} = q_data;

   nfcs_front #(
      .JobAddrW   (JobAddrW),
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .cmd            (req_cmd),
      .target_address (req_target_address[JobAddrW-1:0]),
      .word_in        (req_word_in),
      .ready_pin      (req_ready_pin),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .push           (push),
      .job            (f_job),
      .job_addr       (f_addr)
   );

   nfcs_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({f_job, f_addr}),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_data)
   );

   nfcs_back #(
      .JobAddrW (JobAddrW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_valid),
      .head_job        (q_job),
      .head_addr       (q_addr),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_bus_address (rsp_bus_address),
      .rsp_word_out    (rsp_word_out),
      .rsp_id_index    (rsp_id_index),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule
